// ===== rtl/core/onewire_temperature_read_sequencer_macros.svh =====
// Assertion macros for the 1-Wire temperature read sequencer.
`ifndef ONEWIRE_TEMPERATURE_READ_SEQUENCER_MACROS_SVH
`define ONEWIRE_TEMPERATURE_READ_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OWTR_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OWTR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/owtr_pkg.sv =====
// Shared types and constants of the 1-Wire temperature read sequencer.
`timescale 1ns / 1ps
`default_nettype none
package owtr_pkg;

    localparam int TIMER_W = 20;
    localparam int TEMP_W  = 16;
    localparam int BIT_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index is the word address bit of paddr.
    localparam logic REG_IDX_CONV_WAIT = 1'b0;

    localparam logic [TIMER_W-1:0] CONV_WAIT_RESET = 20'd750000;

    // ROM and function commands, sent LSB first.
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT_T = 8'h44;
    localparam logic [7:0] CMD_READ_SP   = 8'hBE;

    // Segment lengths in microseconds.
    localparam logic [TIMER_W-1:0] T_RST_LOW   = 20'd480;
    localparam logic [TIMER_W-1:0] T_RST_REL   = 20'd70;
    localparam logic [TIMER_W-1:0] T_RST_WAIT  = 20'd410;
    localparam logic [TIMER_W-1:0] T_W1_LOW    = 20'd6;
    localparam logic [TIMER_W-1:0] T_W1_REL    = 20'd64;
    localparam logic [TIMER_W-1:0] T_W0_LOW    = 20'd60;
    localparam logic [TIMER_W-1:0] T_W0_REL    = 20'd10;
    localparam logic [TIMER_W-1:0] T_RD_LOW    = 20'd6;
    localparam logic [TIMER_W-1:0] T_RD_REL    = 20'd9;
    localparam logic [TIMER_W-1:0] T_RD_TAIL   = 20'd55;

    localparam logic [BIT_W-1:0] BITS_PER_CMD = 5'd8;
    localparam logic [BIT_W-1:0] BITS_TOTAL   = 5'd16;

    // -999.0 degrees in sixteenths.
    localparam logic [TEMP_W-1:0] ERROR_TEMP = 16'hC190;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              no_sensor;
        logic [TEMP_W-1:0] temperature;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/owtr_in_if.sv =====
// Input item channel: tick or start, with the sampled bus level.
`timescale 1ns / 1ps
`default_nettype none
interface owtr_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic line_level;

    modport source (output valid, output kind, output line_level, input ready);
    modport sink (input valid, input kind, input line_level, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/owtr_out_if.sv =====
// Result item channel: bus drive and sequence status.
`timescale 1ns / 1ps
`default_nettype none
interface owtr_out_if;
    logic               valid;
    logic               ready;
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               no_sensor;
    logic signed [15:0] temperature;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output no_sensor, output temperature, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input no_sensor, input temperature, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/owtr_cfg.sv =====
// APB configuration register: conversion wait time.
`timescale 1ns / 1ps
`default_nettype none
module owtr_cfg
    import owtr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [TIMER_W-1:0] conv_wait
);

    logic [TIMER_W-1:0] conv_wait_reg;
    logic               reg_idx;
    logic               wr_en;

    assign reg_idx = paddr[PADDR_W-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_IDX_CONV_WAIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_wait_reg <= CONV_WAIT_RESET;
        end
        else if (wr_en)
        begin
            conv_wait_reg <= pwdata[TIMER_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IDX_CONV_WAIT: prdata = {{(PDATA_W-TIMER_W){1'b0}}, conv_wait_reg};
            default:           prdata = '0;
        endcase
    end

    assign conv_wait = conv_wait_reg;

endmodule
`default_nettype wire

// ===== rtl/core/owtr_core.sv =====
// Sequencer state and one-microsecond step logic.
`timescale 1ns / 1ps
`default_nettype none
module owtr_core
    import owtr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               kind,
    input  wire logic               line_level,
    input  wire logic [TIMER_W-1:0] conv_wait,
    output result_t                 res
);

    typedef enum logic [14:0] {
        PH_IDLE    = 15'b000000000000001,
        PH_R1_LOW  = 15'b000000000000010,
        PH_R1_REL  = 15'b000000000000100,
        PH_R1_WAIT = 15'b000000000001000,
        PH_W1_LOW  = 15'b000000000010000,
        PH_W1_REL  = 15'b000000000100000,
        PH_CONV    = 15'b000000001000000,
        PH_R2_LOW  = 15'b000000010000000,
        PH_R2_REL  = 15'b000000100000000,
        PH_R2_WAIT = 15'b000001000000000,
        PH_W2_LOW  = 15'b000010000000000,
        PH_W2_REL  = 15'b000100000000000,
        PH_RD_LOW  = 15'b001000000000000,
        PH_RD_REL  = 15'b010000000000000,
        PH_RD_TAIL = 15'b100000000000000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [TEMP_W-1:0]  rd_reg, rd_next;
    logic               pres_reg, pres_next;
    logic [TEMP_W-1:0]  temp_reg, temp_next;
    logic               err_reg, err_next;
    logic               done;
    logic [BIT_W-1:0]   bit_inc;
    logic [7:0]         cmd_sh;

    assign bit_inc = bit_reg + 5'd1;

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_next   = bit_reg;
        cmd_next   = cmd_reg;
        rd_next    = rd_reg;
        pres_next  = pres_reg;
        temp_next  = temp_reg;
        err_next   = err_reg;
        done       = 1'b0;
        cmd_sh     = {1'b0, cmd_reg[7:1]};

        if (kind)
        begin
            // Start only from idle; otherwise the item is a no-op.
            if (phase_reg == PH_IDLE)
            begin
                phase_next = PH_R1_LOW;
                timer_next = T_RST_LOW;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (timer_reg != '0)
            begin
                timer_next = timer_reg - 20'd1;
            end
            if (timer_next == '0)
            begin
                unique case (phase_reg)
                    PH_R1_LOW:
                    begin
                        phase_next = PH_R1_REL;
                        timer_next = T_RST_REL;
                    end
                    PH_R1_REL:
                    begin
                        pres_next  = !line_level;
                        phase_next = PH_R1_WAIT;
                        timer_next = T_RST_WAIT;
                    end
                    PH_R1_WAIT:
                    begin
                        if (!pres_reg)
                        begin
                            temp_next  = ERROR_TEMP;
                            err_next   = 1'b1;
                            phase_next = PH_IDLE;
                            timer_next = '0;
                            done       = 1'b1;
                        end
                        else
                        begin
                            cmd_next   = CMD_SKIP_ROM;
                            bit_next   = '0;
                            phase_next = PH_W1_LOW;
                            timer_next = CMD_SKIP_ROM[0] ? T_W1_LOW : T_W0_LOW;
                        end
                    end
                    PH_W1_LOW, PH_W2_LOW:
                    begin
                        phase_next = (phase_reg == PH_W1_LOW) ? PH_W1_REL : PH_W2_REL;
                        timer_next = cmd_reg[0] ? T_W1_REL : T_W0_REL;
                    end
                    PH_W1_REL, PH_W2_REL:
                    begin
                        // Shift out the sent bit; switch to the function byte at eight.
                        if (bit_inc == BITS_PER_CMD)
                        begin
                            cmd_sh = (phase_reg == PH_W1_REL) ? CMD_CONVERT_T : CMD_READ_SP;
                        end
                        cmd_next = cmd_sh;
                        bit_next = bit_inc;
                        if (bit_inc >= BITS_TOTAL)
                        begin
                            if (phase_reg == PH_W1_REL)
                            begin
                                if (conv_wait == '0)
                                begin
                                    phase_next = PH_R2_LOW;
                                    timer_next = T_RST_LOW;
                                end
                                else
                                begin
                                    phase_next = PH_CONV;
                                    timer_next = conv_wait;
                                end
                            end
                            else
                            begin
                                bit_next   = '0;
                                rd_next    = '0;
                                phase_next = PH_RD_LOW;
                                timer_next = T_RD_LOW;
                            end
                        end
                        else
                        begin
                            phase_next = (phase_reg == PH_W1_REL) ? PH_W1_LOW : PH_W2_LOW;
                            timer_next = cmd_sh[0] ? T_W1_LOW : T_W0_LOW;
                        end
                    end
                    PH_CONV:
                    begin
                        phase_next = PH_R2_LOW;
                        timer_next = T_RST_LOW;
                    end
                    PH_R2_LOW:
                    begin
                        phase_next = PH_R2_REL;
                        timer_next = T_RST_REL;
                    end
                    PH_R2_REL:
                    begin
                        phase_next = PH_R2_WAIT;
                        timer_next = T_RST_WAIT;
                    end
                    PH_R2_WAIT:
                    begin
                        cmd_next   = CMD_SKIP_ROM;
                        bit_next   = '0;
                        phase_next = PH_W2_LOW;
                        timer_next = CMD_SKIP_ROM[0] ? T_W1_LOW : T_W0_LOW;
                    end
                    PH_RD_LOW:
                    begin
                        phase_next = PH_RD_REL;
                        timer_next = T_RD_REL;
                    end
                    PH_RD_REL:
                    begin
                        rd_next    = {line_level, rd_reg[TEMP_W-1:1]};
                        phase_next = PH_RD_TAIL;
                        timer_next = T_RD_TAIL;
                    end
                    PH_RD_TAIL:
                    begin
                        bit_next = bit_inc;
                        if (bit_inc >= BITS_TOTAL)
                        begin
                            temp_next  = rd_reg;
                            err_next   = 1'b0;
                            phase_next = PH_IDLE;
                            timer_next = '0;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RD_LOW;
                            timer_next = T_RD_LOW;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            bit_reg   <= '0;
            cmd_reg   <= '0;
            rd_reg    <= '0;
            pres_reg  <= 1'b0;
            temp_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            cmd_reg   <= cmd_next;
            rd_reg    <= rd_next;
            pres_reg  <= pres_next;
            temp_reg  <= temp_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        res.drive_low   = (phase_next == PH_R1_LOW) || (phase_next == PH_W1_LOW) ||
                          (phase_next == PH_R2_LOW) || (phase_next == PH_W2_LOW) ||
                          (phase_next == PH_RD_LOW);
        res.busy_res    = (phase_next != PH_IDLE);
        res.done_res    = done;
        res.no_sensor   = err_next;
        res.temperature = temp_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/onewire_temperature_read_sequencer.sv =====
// Top level of the 1-Wire temperature read sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "onewire_temperature_read_sequencer_macros.svh"

// 1-Wire master that runs one Skip ROM / Convert T / Read Scratchpad
// temperature read. Each input transfer is either a one-microsecond tick
// carrying the sampled bus level, or a start request (ignored unless idle).
// Every input transfer yields exactly one result transfer with the level to
// drive for the next microsecond, busy/done status, the no-sensor flag and
// the last temperature in signed sixteenths of a degree C (-999.0 degrees
// after a missing presence pulse). Throughput is one transfer per clock
// while the sink takes results; each input transfer passes through the
// input register, then the step logic into the result register. The
// sequencer state is written once per item, in the same cycle the result
// register loads, so consecutive items chain without bubbles.
// The conversion wait (APB register 0, 20 bits, reset 750000 us) is sampled
// when the wait starts; write it only while the sequencer is idle.
module onewire_temperature_read_sequencer
    import owtr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    owtr_in_if.sink                 tick,
    owtr_out_if.source              result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic               in_valid_reg;
    logic               kind_reg;
    logic               line_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            step_res;
    logic               advance;
    logic               step;
    logic [TIMER_W-1:0] conv_wait;

    // Result register drains or is empty: move the pipeline forward.
    assign advance    = !out_valid_reg || result.ready;
    // Take a new transfer whenever the input register is free or moving on.
    assign tick.ready = !in_valid_reg || advance;
    // Apply one item to the sequencer state.
    assign step       = in_valid_reg && advance;

    owtr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .conv_wait (conv_wait)
    );

    owtr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .kind       (kind_reg),
        .line_level (line_reg),
        .conv_wait  (conv_wait),
        .res        (step_res)
    );

    // Input register: hold the item until the step logic takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            kind_reg <= tick.kind;
            line_reg <= tick.line_level;
        end
    end

    // Result register: hold the result until the sink takes the transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= step_res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.drive_low   = out_reg.drive_low;
    assign result.busy_res    = out_reg.busy_res;
    assign result.done_res    = out_reg.done_res;
    assign result.no_sensor   = out_reg.no_sensor;
    assign result.temperature = out_reg.temperature;

    // A finished sequence is never still busy, and the bus is only pulled
    // low while a sequence runs.
    `OWTR_ASSERT_SAME(a_done_not_busy, out_valid_reg && out_reg.done_res, !out_reg.busy_res, "done while busy")
    `OWTR_ASSERT_SAME(a_drive_needs_busy, out_valid_reg && out_reg.drive_low, out_reg.busy_res, "drive low while idle")
    // A missing sensor always reports the error temperature.
    `OWTR_ASSERT_SAME(a_err_temp, out_valid_reg && out_reg.done_res && out_reg.no_sensor, out_reg.temperature == ERROR_TEMP, "bad error temperature")
    // A held input item is not dropped while the result side stalls.
    `OWTR_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance, in_valid_reg, "input item dropped")

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the 1-Wire temperature read sequencer.
`timescale 1ns / 1ps
module testbench;
    import owtr_pkg::*;

    // Item kinds on the tick channel
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // The conversion wait register is register 0, one 32-bit word per register
    localparam logic [PADDR_W-1:0] ADDR_CONV_WAIT = PADDR_W'({REG_IDX_CONV_WAIT, 2'b00});
    localparam logic [TIMER_W-1:0] CONV_WAIT_AT_RESET = 20'd750000;
    localparam logic [TIMER_W-1:0] CONV_WAIT_MAX      = 20'hFFFFF;

    // Bus segment lengths in microseconds, kept apart from the RTL package
    localparam logic [TIMER_W-1:0] US_RST_LOW   = 20'd480;
    localparam logic [TIMER_W-1:0] US_RST_REL   = 20'd70;
    localparam logic [TIMER_W-1:0] US_RST_WAIT  = 20'd410;
    localparam logic [TIMER_W-1:0] US_ONE_LOW   = 20'd6;
    localparam logic [TIMER_W-1:0] US_ONE_REL   = 20'd64;
    localparam logic [TIMER_W-1:0] US_ZERO_LOW  = 20'd60;
    localparam logic [TIMER_W-1:0] US_ZERO_REL  = 20'd10;
    localparam logic [TIMER_W-1:0] US_READ_LOW  = 20'd6;
    localparam logic [TIMER_W-1:0] US_READ_REL  = 20'd9;
    localparam logic [TIMER_W-1:0] US_READ_TAIL = 20'd55;

    // Cycles without any transfer on either channel before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic [4:0] {
        SEQ_IDLE,
        SEQ_RST1_LOW,
        SEQ_RST1_REL,
        SEQ_RST1_WAIT,
        SEQ_CMD1_LOW,
        SEQ_CMD1_REL,
        SEQ_CONVERT,
        SEQ_RST2_LOW,
        SEQ_RST2_REL,
        SEQ_RST2_WAIT,
        SEQ_CMD2_LOW,
        SEQ_CMD2_REL,
        SEQ_READ_LOW,
        SEQ_READ_REL,
        SEQ_READ_TAIL
    } seq_phase_e;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    owtr_in_if  tick_if ();
    owtr_out_if result_if ();

    onewire_temperature_read_sequencer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Sequencer state as the testbench tracks it, updated on every accepted transfer
    seq_phase_e         seq_phase;
    logic [TIMER_W-1:0] seq_timer;
    logic [TIMER_W-1:0] conv_wait;
    logic [4:0]         seq_bit;
    logic [7:0]         cmd_byte;
    logic [15:0]        scratch;
    logic               presence;
    logic [15:0]        held_temp;
    logic               held_error;

    // Bus status each accepted item must produce, oldest first
    result_t status_due[$];
    int      errors;

    // Pacing switches: random sender gaps, random receiver stalls
    logic pace_gaps;
    logic pace_stalls;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sequencer behavior
    // ------------------------------------------------------------------

    task sequencer_reset();
        seq_phase  = SEQ_IDLE;
        seq_timer  = '0;
        conv_wait  = CONV_WAIT_AT_RESET;
        seq_bit    = '0;
        cmd_byte   = '0;
        scratch    = '0;
        presence   = 1'b0;
        held_temp  = '0;
        held_error = 1'b0;
    endtask

    task load_segment(input seq_phase_e ph, input logic [TIMER_W-1:0] len);
        seq_phase = ph;
        seq_timer = len;
    endtask

    // Slot lengths follow the command bit going out next (LSB of the shifter)
    task load_write_low(input seq_phase_e ph);
        load_segment(ph, cmd_byte[0] ? US_ONE_LOW : US_ZERO_LOW);
    endtask

    task load_write_rel(input seq_phase_e ph);
        load_segment(ph, cmd_byte[0] ? US_ONE_REL : US_ZERO_REL);
    endtask

    // Close the running segment; the line level of this tick is the sample point
    task end_segment(input logic line, output logic finished);
        finished = 1'b0;
        case (seq_phase)
            SEQ_RST1_LOW: load_segment(SEQ_RST1_REL, US_RST_REL);
            SEQ_RST1_REL:
            begin
                // a sensor answers by holding the line low
                presence = ~line;
                load_segment(SEQ_RST1_WAIT, US_RST_WAIT);
            end
            SEQ_RST1_WAIT:
            begin
                if (!presence)
                begin
                    held_temp  = ERROR_TEMP;
                    held_error = 1'b1;
                    load_segment(SEQ_IDLE, '0);
                    finished = 1'b1;
                end
                else
                begin
                    cmd_byte = CMD_SKIP_ROM;
                    seq_bit  = '0;
                    load_write_low(SEQ_CMD1_LOW);
                end
            end
            SEQ_CMD1_LOW: load_write_rel(SEQ_CMD1_REL);
            SEQ_CMD2_LOW: load_write_rel(SEQ_CMD2_REL);
            SEQ_CMD1_REL, SEQ_CMD2_REL:
            begin
                cmd_byte = cmd_byte >> 1;
                seq_bit  = seq_bit + 1'b1;
                // second byte of each pair is the function command
                if (seq_bit == 5'd8)
                    cmd_byte = (seq_phase == SEQ_CMD1_REL) ? CMD_CONVERT_T : CMD_READ_SP;
                if (seq_bit >= 5'd16)
                begin
                    if (seq_phase == SEQ_CMD1_REL)
                    begin
                        // a zero wait skips the conversion segment entirely
                        if (conv_wait == '0)
                            load_segment(SEQ_RST2_LOW, US_RST_LOW);
                        else
                            load_segment(SEQ_CONVERT, conv_wait);
                    end
                    else
                    begin
                        seq_bit = '0;
                        scratch = '0;
                        load_segment(SEQ_READ_LOW, US_READ_LOW);
                    end
                end
                else
                begin
                    load_write_low(seq_phase == SEQ_CMD1_REL ? SEQ_CMD1_LOW : SEQ_CMD2_LOW);
                end
            end
            SEQ_CONVERT:  load_segment(SEQ_RST2_LOW, US_RST_LOW);
            SEQ_RST2_LOW: load_segment(SEQ_RST2_REL, US_RST_REL);
            // the second reset does not look at presence
            SEQ_RST2_REL: load_segment(SEQ_RST2_WAIT, US_RST_WAIT);
            SEQ_RST2_WAIT:
            begin
                cmd_byte = CMD_SKIP_ROM;
                seq_bit  = '0;
                load_write_low(SEQ_CMD2_LOW);
            end
            SEQ_READ_LOW: load_segment(SEQ_READ_REL, US_READ_REL);
            SEQ_READ_REL:
            begin
                // bits arrive LSB first, shift in from the top
                scratch = {line, scratch[15:1]};
                load_segment(SEQ_READ_TAIL, US_READ_TAIL);
            end
            SEQ_READ_TAIL:
            begin
                seq_bit = seq_bit + 1'b1;
                if (seq_bit >= 5'd16)
                begin
                    held_temp  = scratch;
                    held_error = 1'b0;
                    load_segment(SEQ_IDLE, '0);
                    finished = 1'b1;
                end
                else
                begin
                    load_segment(SEQ_READ_LOW, US_READ_LOW);
                end
            end
            default: load_segment(SEQ_IDLE, '0);
        endcase
    endtask

    // Advance by one item and return the bus status it produces
    task sequencer_step(input logic kind, input logic line, output result_t status);
        logic finished;
        finished = 1'b0;
        if (kind == KIND_START)
        begin
            // start while busy is dropped without consuming a microsecond
            if (seq_phase == SEQ_IDLE)
                load_segment(SEQ_RST1_LOW, US_RST_LOW);
        end
        else if (seq_phase != SEQ_IDLE)
        begin
            if (seq_timer != '0)
                seq_timer = seq_timer - 1'b1;
            if (seq_timer == '0)
                end_segment(line, finished);
        end
        status.drive_low   = seq_phase inside {SEQ_RST1_LOW, SEQ_CMD1_LOW, SEQ_RST2_LOW,
                                               SEQ_CMD2_LOW, SEQ_READ_LOW};
        status.busy_res    = (seq_phase != SEQ_IDLE);
        status.done_res    = finished;
        status.no_sensor   = held_error;
        status.temperature = held_temp;
    endtask

    // ------------------------------------------------------------------
    // Channel and register access
    // ------------------------------------------------------------------

    // Mostly back to back, sometimes a few cycles, rarely a long hold
    function int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task compare_field(input string name, input logic signed [31:0] want,
                       input logic signed [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Send one item; valid stays high into the next item unless a gap is drawn
    task send_item(input logic kind, input logic line);
        int      gap;
        result_t status;
        gap = pace_gaps ? pick_pause() : 0;
        if (gap > 0)
        begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_if.valid      <= 1'b1;
        tick_if.kind       <= kind;
        tick_if.line_level <= line;
        @(posedge clk);
        while (!tick_if.ready)
            @(posedge clk);
        sequencer_step(kind, line, status);
        status_due.push_back(status);
    endtask

    // Drop valid and hold until every expected status has come back
    task wait_results_settled();
        tick_if.valid <= 1'b0;
        @(posedge clk);
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready
    task reg_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                    output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_CONV_WAIT;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write the conversion wait while idle, then read it back
    task set_conversion_wait(input logic [TIMER_W-1:0] us);
        logic [PDATA_W-1:0] wdata;
        logic [PDATA_W-1:0] rdata;
        wait_results_settled();
        // junk in the unused upper bits must not reach the register
        wdata = $urandom;
        wdata[TIMER_W-1:0] = us;
        reg_access(1'b1, wdata, rdata);
        conv_wait = us;
        reg_access(1'b0, '0, rdata);
        compare_field("conversion_wait_us", us, rdata[TIMER_W-1:0]);
    endtask

    // Run one read from start to finish. The line is steered only where the
    // sequencer samples it: presence at the end of the first reset release,
    // and each data bit at the end of a read slot release. Elsewhere it is
    // random. start_noise_pm sprinkles starts while busy (per mille);
    // hold_at pauses the sender at that item until all status has returned.
    task run_read(input logic present, input logic [15:0] reading,
                  input int start_noise_pm, input int hold_at);
        int   n;
        logic line;
        n = 0;
        send_item(KIND_START, 1'($urandom_range(0, 1)));
        while (seq_phase != SEQ_IDLE)
        begin
            if (n == hold_at)
                wait_results_settled();
            if ($urandom_range(0, 999) < start_noise_pm)
            begin
                send_item(KIND_START, 1'($urandom_range(0, 1)));
            end
            else
            begin
                line = 1'($urandom_range(0, 1));
                if (seq_timer == 20'd1 && seq_phase == SEQ_RST1_REL)
                    line = ~present;
                if (seq_timer == 20'd1 && seq_phase == SEQ_READ_REL)
                    line = reading[seq_bit[3:0]];
                send_item(KIND_TICK, line);
            end
            n++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register reset value, then ticks at idle with both line levels
    task test_idle_ticks();
        logic [PDATA_W-1:0] rdata;
        pace_gaps   = 1'b0;
        pace_stalls = 1'b0;
        reg_access(1'b0, '0, rdata);
        compare_field("conversion_wait_us", CONV_WAIT_AT_RESET, rdata[TIMER_W-1:0]);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b1);
        repeat (6) send_item(KIND_TICK, 1'($urandom_range(0, 1)));
    endtask

    // No presence pulse: error temperature, no_sensor set; starts while busy ignored
    task test_missing_sensor();
        pace_gaps   = 1'b1;
        pace_stalls = 1'b1;
        run_read(1'b0, '0, 20, -1);
        send_item(KIND_TICK, 1'b1);
    endtask

    // Zero conversion wait skips the wait segment; most negative reading.
    // Halfway through, hold the sender until every status is back.
    task test_zero_wait_read();
        set_conversion_wait('0);
        pace_gaps   = 1'b1;
        pace_stalls = 1'b1;
        run_read(1'b1, 16'h8000, 5, 2500);
    endtask

    // Shortest real wait, most positive reading, no idling on either side
    task test_one_us_wait_read();
        set_conversion_wait(20'd1);
        pace_gaps   = 1'b0;
        pace_stalls = 1'b0;
        run_read(1'b1, 16'h7FFF, 5, -1);
    endtask

    // Longest wait is too long to sit through; run it with an absent sensor
    task test_longest_wait();
        set_conversion_wait(CONV_WAIT_MAX);
        pace_gaps   = 1'b1;
        pace_stalls = 1'b0;
        run_read(1'b0, '0, 5, -1);
        // a sensor appearing on the next read clears no_sensor
        set_conversion_wait(20'd3);
        run_read(1'b1, 16'hFFFF, 5, -1);
    endtask

    // Mostly well-formed reads with random content and waits; some broken
    task test_random_reads();
        int          pick;
        logic [19:0] conv_us;
        logic        present;
        repeat (6)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                conv_us = '0;
            else if (pick == 1)
                conv_us = 20'd1;
            else
                conv_us = 20'($urandom_range(2, 400));
            set_conversion_wait(conv_us);
            pace_gaps   = ($urandom_range(0, 3) != 0);
            pace_stalls = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 8))
                send_item(KIND_TICK, 1'($urandom_range(0, 1)));
            present = ($urandom_range(0, 99) < 85);
            run_read(present, 16'($urandom), $urandom_range(0, 30),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000) : -1);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking: compare each status transfer against the oldest due
    // ------------------------------------------------------------------

    initial
    begin : status_checker
        result_t want;
        int      stall;
        stall = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    want = status_due.pop_front();
                    compare_field("drive_low", want.drive_low, result_if.drive_low);
                    compare_field("busy_res", want.busy_res, result_if.busy_res);
                    compare_field("done_res", want.done_res, result_if.done_res);
                    compare_field("no_sensor", want.no_sensor, result_if.no_sensor);
                    compare_field("temperature", $signed(want.temperature),
                                  $signed(result_if.temperature));
                end
            end
            // Drop ready for a drawn number of cycles, otherwise hold it high
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_if.ready <= 1'b1;
                stall = pace_stalls ? pick_pause() : 0;
            end
        end
    end

    // Stop a hung run: count cycles in which neither channel moves a transfer
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tick_if.valid && tick_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        errors      = 0;
        pace_gaps   = 1'b0;
        pace_stalls = 1'b0;
        sequencer_reset();
        rst_n              <= 1'b0;
        tick_if.valid      <= 1'b0;
        tick_if.kind       <= KIND_TICK;
        tick_if.line_level <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_missing_sensor();
        test_zero_wait_read();
        test_one_us_wait_read();
        test_longest_wait();
        test_random_reads();

        // Let the last status transfers drain, plus a margin over the latency
        wait_results_settled();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
